// ===== sv/assert_macros.svh =====
// assertion helpers for the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ilh_pkg.sv =====
`default_nettype none
package ilh_pkg;

  localparam int KEY_W     = 64;
  localparam int TS_W      = 64;
  localparam int CNT_W     = 64;
  localparam int MODE_W    = 2;
  localparam int KIND_W    = 2;
  localparam int SEL_W     = 5;
  localparam int BIN_OUT_W = 5;

  localparam int TABLE_ENTRIES = 1024;
  localparam int HIST_BINS     = 32;
  localparam int CALL_KINDS    = 3;

  // slot table split over a row of cells, each with its own bank
  localparam int CELLS      = 32;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int SLOTS_NEED = (TABLE_ENTRIES + CELLS - 1) / CELLS;
  localparam int SLOT_W     = (SLOTS_NEED > 2) ? $clog2(SLOTS_NEED) : 1;
  localparam int SLOTS      = 1 << SLOT_W;
  localparam int IDX_W      = CELL_W + SLOT_W;

  localparam int HIST_DEPTH = CALL_KINDS * HIST_BINS;
  localparam int HADDR_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  localparam int CLR_LEN = (SLOTS > HIST_DEPTH) ? SLOTS : HIST_DEPTH;
  localparam int CLR_W   = $clog2(CLR_LEN);

  localparam int LOG_W     = 6;
  localparam int LOG_STEPS = 6;
  localparam int STEP_W    = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENTER,
    MODE_EXIT,
    MODE_READ_BIN,
    MODE_READ_DROP
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CHAIN,
    ST_DECIDE,
    ST_RSTART,
    ST_LOG,
    ST_HADDR,
    ST_HREAD,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TS_W-1:0]   start;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic              scan_clr;
    logic              chk_en;
    logic [SLOT_W-1:0] chk_addr;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_all;
    logic              wr_en;
    logic [CELL_W-1:0] wr_cell;
    logic [SLOT_W-1:0] wr_addr;
    row_t              wr_row;
  } cell_cmd_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } chain_t;

  // shift amounts of the floor(log2) search, one per step
  function automatic logic [LOG_W-1:0] log2_shift(input logic [STEP_W-1:0] step);
    logic [LOG_W-1:0] sh;
    unique case (step)
      3'd0:    sh = LOG_W'(32);
      3'd1:    sh = LOG_W'(16);
      3'd2:    sh = LOG_W'(8);
      3'd3:    sh = LOG_W'(4);
      3'd4:    sh = LOG_W'(2);
      3'd5:    sh = LOG_W'(1);
      default: sh = '0;
    endcase
    return sh;
  endfunction

endpackage
`default_nettype wire

// ===== sv/interval_latency_log2_histogram_unit.sv =====
// channel  | ports                                  | handshake
// ---------+----------------------------------------+--------------------------------
// request  | in_mode in_task_key in_timestamp_ns    | start high while busy low
//          | in_passes_filter in_call_kind          |
//          | in_bin_select                          |
// result   | out_start_stored out_recorded          | out_valid high for one cycle
//          | out_bin_used out_count_value           |
//
// after reset a clearing pass empties the slot banks and histogram; busy is high
// enter and exit: bank scan, drain, pass down the cell row, decide; filtered enter skips all
// an exit that hits adds an entry free, a log2 search and a histogram read-modify-write
// drop reads go straight to the reply, bin reads through an address and a read state
// one request at a time; the result comes in the cycle before idle and cannot be stalled
`default_nettype none
`include "assert_macros.svh"
module interval_latency_log2_histogram_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ilh_pkg::MODE_W-1:0]    in_mode,
  input  logic [ilh_pkg::KEY_W-1:0]     in_task_key,
  input  logic [ilh_pkg::TS_W-1:0]      in_timestamp_ns,
  input  logic                          in_passes_filter,
  input  logic [ilh_pkg::KIND_W-1:0]    in_call_kind,
  input  logic [ilh_pkg::SEL_W-1:0]     in_bin_select,
  output logic                          out_valid,
  output logic                          out_start_stored,
  output logic                          out_recorded,
  output logic [ilh_pkg::BIN_OUT_W-1:0] out_bin_used,
  output logic [ilh_pkg::CNT_W-1:0]     out_count_value
);
  import ilh_pkg::*;

  state_t             state_r, state_nxt;
  logic [CLR_W-1:0]   clr_r, clr_nxt;
  logic [SLOT_W-1:0]  scan_r, scan_nxt;
  logic [CELL_W-1:0]  wait_r, wait_nxt;
  logic               chk_en_r;
  logic [SLOT_W-1:0]  chk_addr_r;
  mode_t              mode_r, mode_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [TS_W-1:0]    ts_r, ts_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [LOG_W-1:0]   bin_r, bin_nxt;
  logic [HADDR_W-1:0] hidx_r, hidx_nxt;
  logic [CNT_W-1:0]   drop_r, drop_nxt;
  logic               res_stored_r, res_stored_nxt;
  logic               res_rec_r, res_rec_nxt;
  logic [LOG_W-1:0]   res_bin_r, res_bin_nxt;
  logic [CNT_W-1:0]   res_cnt_r, res_cnt_nxt;

  cell_cmd_t          cmd;
  chain_t             chain [CELLS+1];
  chain_t             fin;
  logic [TS_W-1:0]    cell_start [CELLS];
  logic [TS_W-1:0]    start_sel;

  logic               h_we;
  logic [HADDR_W-1:0] h_waddr;
  logic [CNT_W-1:0]   h_wdata;
  logic [CNT_W-1:0]   h_rdata;

  logic               lg_go;
  logic               lg_done;
  logic [LOG_W-1:0]   lg_result;

  assign chain[0] = '0;
  assign fin      = chain[CELLS];

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    ilh_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (CELL_W'(g)),
      .cmd       (cmd),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .rd_start  (cell_start[g])
    );
  end

  ilh_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (hidx_r),
    .rdata (h_rdata)
  );

  assign start_sel = cell_start[hit_idx_r[IDX_W-1:SLOT_W]];

  ilh_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (lg_go),
    .value  (ts_r - start_sel),
    .done   (lg_done),
    .result (lg_result)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    scan_nxt       = scan_r;
    wait_nxt       = wait_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    ts_nxt         = ts_r;
    kind_nxt       = kind_r;
    hit_idx_nxt    = hit_idx_r;
    bin_nxt        = bin_r;
    hidx_nxt       = hidx_r;
    drop_nxt       = drop_r;
    res_stored_nxt = res_stored_r;
    res_rec_nxt    = res_rec_r;
    res_bin_nxt    = res_bin_r;
    res_cnt_nxt    = res_cnt_r;

    cmd          = '0;
    cmd.chk_en   = chk_en_r;
    cmd.chk_addr = chk_addr_r;
    cmd.key      = key_r;
    cmd.rd_addr  = scan_r;
    cmd.wr_row   = '{valid: 1'b1, key: key_r, start: ts_r};

    h_we    = 1'b0;
    h_waddr = hidx_r;
    h_wdata = h_rdata + 1'b1;
    lg_go   = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        cmd.wr_all  = 32'(clr_r) < SLOTS;
        cmd.wr_addr = clr_r[SLOT_W-1:0];
        cmd.wr_row  = '0;
        h_we        = 32'(clr_r) < HIST_DEPTH;
        h_waddr     = clr_r[HADDR_W-1:0];
        h_wdata     = '0;
        clr_nxt     = clr_r + 1'b1;
        if (clr_r == CLR_W'(CLR_LEN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          mode_nxt       = mode_t'(in_mode);
          key_nxt        = in_task_key;
          ts_nxt         = in_timestamp_ns;
          kind_nxt       = in_call_kind;
          res_stored_nxt = 1'b0;
          res_rec_nxt    = 1'b0;
          res_bin_nxt    = '0;
          res_cnt_nxt    = '0;
          scan_nxt       = '0;
          cmd.scan_clr   = 1'b1;
          unique case (mode_t'(in_mode))
            MODE_ENTER: begin
              state_nxt = in_passes_filter ? ST_SCAN : ST_REPLY;
            end
            MODE_EXIT: begin
              state_nxt = ST_SCAN;
            end
            MODE_READ_BIN: begin
              hidx_nxt = HADDR_W'(32'(in_call_kind) * HIST_BINS + 32'(in_bin_select));
              if (32'(in_call_kind) < CALL_KINDS && 32'(in_bin_select) < HIST_BINS) begin
                state_nxt = ST_HADDR;
              end else begin
                state_nxt = ST_REPLY;
              end
            end
            MODE_READ_DROP: begin
              res_cnt_nxt = drop_r;
              state_nxt   = ST_REPLY;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        scan_nxt = scan_r + 1'b1;
        if (scan_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        wait_nxt  = '0;
        state_nxt = ST_CHAIN;
      end
      ST_CHAIN: begin
        wait_nxt = wait_r + 1'b1;
        if (wait_r == CELL_W'(CELLS - 1)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        hit_idx_nxt = fin.hit_idx;
        cmd.rd_addr = fin.hit_idx[SLOT_W-1:0];
        state_nxt   = ST_REPLY;
        if (mode_r == MODE_ENTER) begin
          if (fin.hit || fin.free) begin
            cmd.wr_en      = 1'b1;
            cmd.wr_cell    = fin.hit ? fin.hit_idx[IDX_W-1:SLOT_W]
                                     : fin.free_idx[IDX_W-1:SLOT_W];
            cmd.wr_addr    = fin.hit ? fin.hit_idx[SLOT_W-1:0]
                                     : fin.free_idx[SLOT_W-1:0];
            res_stored_nxt = 1'b1;
          end else begin
            drop_nxt = drop_r + 1'b1;
          end
        end else if (fin.hit) begin
          state_nxt = ST_RSTART;
        end
      end
      ST_RSTART: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_cell = hit_idx_r[IDX_W-1:SLOT_W];
        cmd.wr_addr = hit_idx_r[SLOT_W-1:0];
        cmd.wr_row  = '0;
        lg_go       = 1'b1;
        state_nxt   = ST_LOG;
      end
      ST_LOG: begin
        if (lg_done) begin
          bin_nxt  = (32'(lg_result) >= HIST_BINS) ? LOG_W'(HIST_BINS - 1) : lg_result;
          hidx_nxt = HADDR_W'(32'(kind_r) * HIST_BINS + 32'(bin_nxt));
          if (32'(kind_r) < CALL_KINDS) begin
            state_nxt = ST_HADDR;
          end else begin
            state_nxt = ST_REPLY;
          end
        end
      end
      ST_HADDR: begin
        state_nxt = ST_HREAD;
      end
      ST_HREAD: begin
        if (mode_r == MODE_EXIT) begin
          h_we        = 1'b1;
          res_cnt_nxt = h_wdata;
          res_rec_nxt = 1'b1;
          res_bin_nxt = bin_r;
        end else begin
          res_cnt_nxt = h_rdata;
        end
        state_nxt = ST_REPLY;
      end
      ST_REPLY: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      chk_en_r <= 1'b0;
      drop_r   <= '0;
      scan_r   <= '0;
      wait_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      chk_en_r <= (state_r == ST_SCAN);
      drop_r   <= drop_nxt;
      scan_r   <= scan_nxt;
      wait_r   <= wait_nxt;
    end
    chk_addr_r   <= scan_r;
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    ts_r         <= ts_nxt;
    kind_r       <= kind_nxt;
    hit_idx_r    <= hit_idx_nxt;
    bin_r        <= bin_nxt;
    hidx_r       <= hidx_nxt;
    res_stored_r <= res_stored_nxt;
    res_rec_r    <= res_rec_nxt;
    res_bin_r    <= res_bin_nxt;
    res_cnt_r    <= res_cnt_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_REPLY);
  assign out_start_stored = res_stored_r;
  assign out_recorded     = res_rec_r;
  assign out_bin_used     = res_bin_r[BIN_OUT_W-1:0];
  assign out_count_value  = res_cnt_r;

  `ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_NXT(a_reply_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_IMP(a_one_flag, clk, rst_n, out_valid, !(out_start_stored && out_recorded))
  `ASSERT_IMP(a_drop_src, clk, rst_n, !$stable(drop_r), $past(state_r) == ST_DECIDE)

endmodule
`default_nettype wire

// ===== sv/ilh_ram.sv =====
`default_nettype none
module ilh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/ilh_log2.sv =====
`default_nettype none
module ilh_log2 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [ilh_pkg::TS_W-1:0]  value,
  output logic                      done,
  output logic [ilh_pkg::LOG_W-1:0] result
);
  import ilh_pkg::*;

  logic [TS_W-1:0]   x_r, x_nxt;
  logic [LOG_W-1:0]  r_r, r_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [LOG_W-1:0]  sh;

  always_comb begin
    sh       = log2_shift(step_r);
    x_nxt    = x_r;
    r_nxt    = r_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      x_nxt    = value;
      r_nxt    = '0;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if ((x_r >> sh) != '0) begin
        x_nxt = x_r >> sh;
        r_nxt = r_r + sh;
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(LOG_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    x_r <= x_nxt;
    r_r <= r_nxt;
  end

  assign done   = done_r;
  assign result = r_r;

endmodule
`default_nettype wire

// ===== sv/ilh_cell.sv =====
`default_nettype none
module ilh_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ilh_pkg::CELL_W-1:0] cell_idx,
  input  ilh_pkg::cell_cmd_t         cmd,
  input  ilh_pkg::chain_t            chain_in,
  output ilh_pkg::chain_t            chain_out,
  output logic [ilh_pkg::TS_W-1:0]   rd_start
);
  import ilh_pkg::*;

  logic              we;
  row_t              rdata;
  logic              exists;
  logic              hit_r, hit_nxt;
  logic              free_r, free_nxt;
  logic [SLOT_W-1:0] hit_slot_r, hit_slot_nxt;
  logic [SLOT_W-1:0] free_slot_r, free_slot_nxt;
  chain_t            chain_r, chain_nxt;

  assign we = cmd.wr_all || (cmd.wr_en && (cmd.wr_cell == cell_idx));

  ilh_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS)) u_bank (
    .clk   (clk),
    .we    (we),
    .waddr (cmd.wr_addr),
    .wdata (cmd.wr_row),
    .raddr (cmd.rd_addr),
    .rdata (rdata)
  );

  assign exists = 32'({cell_idx, cmd.chk_addr}) < TABLE_ENTRIES;

  // local search over this bank
  always_comb begin
    hit_nxt       = hit_r;
    free_nxt      = free_r;
    hit_slot_nxt  = hit_slot_r;
    free_slot_nxt = free_slot_r;
    if (cmd.scan_clr) begin
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
    end else if (cmd.chk_en && exists) begin
      if (rdata.valid && (rdata.key == cmd.key) && !hit_r) begin
        hit_nxt      = 1'b1;
        hit_slot_nxt = cmd.chk_addr;
      end
      if (!rdata.valid && !free_r) begin
        free_nxt      = 1'b1;
        free_slot_nxt = cmd.chk_addr;
      end
    end
  end

  // lower cells win, so the first free slot is the lowest one
  always_comb begin
    chain_nxt = chain_in;
    if (!chain_in.hit && hit_r) begin
      chain_nxt.hit     = 1'b1;
      chain_nxt.hit_idx = {cell_idx, hit_slot_r};
    end
    if (!chain_in.free && free_r) begin
      chain_nxt.free     = 1'b1;
      chain_nxt.free_idx = {cell_idx, free_slot_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else begin
      hit_r  <= hit_nxt;
      free_r <= free_nxt;
    end
    hit_slot_r  <= hit_slot_nxt;
    free_slot_r <= free_slot_nxt;
    chain_r     <= chain_nxt;
  end

  assign chain_out = chain_r;
  assign rd_start  = rdata.start;

endmodule
`default_nettype wire

// ===== dv/tb_interval_latency_log2_histogram_unit.sv =====
`default_nettype none
module tb_interval_latency_log2_histogram_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ilh_pkg::*;

  localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OPENAT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int POOL_SIZE   = 24;
  localparam int TAIL_ITEMS  = 40;
  localparam int DRAIN_WAIT  = 120;

  typedef struct {
    logic                 stored;
    logic                 recorded;
    logic [BIN_OUT_W-1:0] bin;
    logic [CNT_W-1:0]     count;
  } latency_result_t;

  class latency_scoreboard;
    logic [KEY_W-1:0] slot_key   [TABLE_ENTRIES];
    bit               slot_used  [TABLE_ENTRIES];
    logic [TS_W-1:0]  slot_start [TABLE_ENTRIES];
    logic [CNT_W-1:0] bin_count  [HIST_DEPTH];
    logic [CNT_W-1:0] drops;
    latency_result_t  pending [$];
    int               fails;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i]  = 1'b0;
        slot_key[i]   = '0;
        slot_start[i] = '0;
      end
      foreach (bin_count[i]) bin_count[i] = '0;
      drops = '0;
      fails = 0;
    endfunction

    function int lookup(logic [KEY_W-1:0] key);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_used[i] && slot_key[i] == key) return i;
      end
      return -1;
    endfunction

    function int first_free();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!slot_used[i]) return i;
      end
      return -1;
    endfunction

    function logic [BIN_OUT_W-1:0] latency_bin(logic [TS_W-1:0] delta);
      int top;
      top = 0;
      for (int b = 0; b < TS_W; b++) begin
        if (delta[b]) top = b;
      end
      if (top >= HIST_BINS) top = HIST_BINS - 1;
      return BIN_OUT_W'(top);
    endfunction

    function void note_request(mode_t mode, logic [KEY_W-1:0] key, logic [TS_W-1:0] ts,
                               logic pass, logic [KIND_W-1:0] kind, logic [SEL_W-1:0] sel);
      latency_result_t r;
      int s;
      int idx;
      logic [BIN_OUT_W-1:0] b;
      r = '{default: '0};
      case (mode)
        MODE_ENTER: begin
          if (pass) begin
            s = lookup(key);
            if (s < 0) s = first_free();
            if (s >= 0) begin
              slot_key[s]   = key;
              slot_start[s] = ts;
              slot_used[s]  = 1'b1;
              r.stored      = 1'b1;
            end else begin
              drops++;
            end
          end
        end
        MODE_EXIT: begin
          s = lookup(key);
          if (s >= 0) begin
            slot_used[s] = 1'b0;
            b = latency_bin(ts - slot_start[s]);
            if (kind < CALL_KINDS) begin
              idx = kind * HIST_BINS + b;
              bin_count[idx]++;
              r.recorded = 1'b1;
              r.bin      = b;
              r.count    = bin_count[idx];
            end
          end
        end
        MODE_READ_BIN: begin
          if (kind < CALL_KINDS && sel < HIST_BINS) r.count = bin_count[kind * HIST_BINS + sel];
        end
        MODE_READ_DROP: begin
          r.count = drops;
        end
      endcase
      pending.push_back(r);
    endfunction

    task report(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fails++;
    endtask

    task check_result(logic stored, logic recorded, logic [BIN_OUT_W-1:0] bin,
                      logic [CNT_W-1:0] count);
      latency_result_t want;
      if (pending.size() == 0) begin
        report("result with no request", CNT_W'(count), '0);
        return;
      end
      want = pending.pop_front();
      if (stored !== want.stored) report("start_stored", CNT_W'(stored), CNT_W'(want.stored));
      if (recorded !== want.recorded) begin
        report("recorded", CNT_W'(recorded), CNT_W'(want.recorded));
      end
      if (bin !== want.bin) report("bin_used", CNT_W'(bin), CNT_W'(want.bin));
      if (count !== want.count) report("count_value", count, want.count);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [MODE_W-1:0]    in_mode = '0;
  logic [KEY_W-1:0]     in_task_key = '0;
  logic [TS_W-1:0]      in_timestamp_ns = '0;
  logic                 in_passes_filter = 1'b0;
  logic [KIND_W-1:0]    in_call_kind = '0;
  logic [SEL_W-1:0]     in_bin_select = '0;
  logic                 out_valid;
  logic                 out_start_stored;
  logic                 out_recorded;
  logic [BIN_OUT_W-1:0] out_bin_used;
  logic [CNT_W-1:0]     out_count_value;

  latency_scoreboard latency_sb = new();
  int unsigned       cycles = 0;
  bit                allow_idle = 1'b1;
  int                idle_odds = 30;
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  interval_latency_log2_histogram_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_task_key      (in_task_key),
    .in_timestamp_ns  (in_timestamp_ns),
    .in_passes_filter (in_passes_filter),
    .in_call_kind     (in_call_kind),
    .in_bin_select    (in_bin_select),
    .out_valid        (out_valid),
    .out_start_stored (out_start_stored),
    .out_recorded     (out_recorded),
    .out_bin_used     (out_bin_used),
    .out_count_value  (out_count_value)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("interval_latency_log2_histogram_unit regression: fail");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        latency_sb.check_result(out_start_stored, out_recorded, out_bin_used, out_count_value);
      end
      if (start && !busy) begin
        latency_sb.note_request(mode_t'(in_mode), in_task_key, in_timestamp_ns,
                                in_passes_filter, in_call_kind, in_bin_select);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TS_W-1:0] random_delta();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return rand64() >> $urandom_range(0, 64);
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] random_kind();
    if ($urandom_range(0, 9) == 0) return KIND_NONE;
    return KIND_W'($urandom_range(0, CALL_KINDS - 1));
  endfunction

  task automatic maybe_idle();
    int n;
    if (allow_idle && $urandom_range(0, 99) < idle_odds) begin
      n = $urandom_range(1, 7);
      start = 1'b0;
      repeat (n) begin
        in_mode          = MODE_W'($urandom);
        in_task_key      = rand64();
        in_timestamp_ns  = rand64();
        in_passes_filter = 1'($urandom);
        in_call_kind     = KIND_W'($urandom);
        in_bin_select    = SEL_W'($urandom);
        @(negedge clk);
      end
    end
  endtask

  task automatic send(mode_t mode, logic [KEY_W-1:0] key, logic [TS_W-1:0] ts, logic pass,
                      logic [KIND_W-1:0] kind, logic [SEL_W-1:0] sel);
    in_mode          = mode;
    in_task_key      = key;
    in_timestamp_ns  = ts;
    in_passes_filter = pass;
    in_call_kind     = kind;
    in_bin_select    = sel;
    start            = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    maybe_idle();
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (latency_sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic send_exit(logic [KEY_W-1:0] key, logic [KIND_W-1:0] kind);
    int s;
    s = latency_sb.lookup(key);
    send(MODE_EXIT, key, (s >= 0) ? latency_sb.slot_start[s] + random_delta() : rand64(),
         1'($urandom), kind, SEL_W'($urandom));
  endtask

  task automatic directed_requests();
    logic [KEY_W-1:0] k0;
    logic [KEY_W-1:0] k2;
    logic [KEY_W-1:0] k3;
    k0 = '0;
    k2 = 64'h0123_4567_89ab_cdef;
    k3 = 64'h8000_0000_0000_0001;
    send(MODE_READ_DROP, '0, '0, 1'b0, KIND_READ, '0);
    send(MODE_READ_BIN, '0, '0, 1'b0, KIND_READ, '0);
    send(MODE_READ_BIN, '1, '1, 1'b1, KIND_OPENAT, SEL_W'(HIST_BINS - 1));
    send(MODE_READ_BIN, '0, '0, 1'b0, KIND_NONE, SEL_W'(HIST_BINS - 1));
    // filtered enter, then an exit that finds nothing
    send(MODE_ENTER, k0, '0, 1'b0, KIND_READ, '0);
    send(MODE_EXIT, k0, '0, 1'b0, KIND_READ, '0);
    // zero latency
    send(MODE_ENTER, k0, '0, 1'b1, KIND_READ, '0);
    send(MODE_EXIT, k0, '0, 1'b0, KIND_READ, '0);
    // timestamp wraps past zero
    send(MODE_ENTER, '1, '1, 1'b1, KIND_NONE, '1);
    send(MODE_EXIT, '1, '0, 1'b1, KIND_WRITE, '1);
    // overwrite of a stored start
    send(MODE_ENTER, k2, 64'd5, 1'b1, KIND_READ, '0);
    send(MODE_ENTER, k2, 64'd100, 1'b1, KIND_READ, '0);
    send(MODE_EXIT, k2, 64'd102, 1'b0, KIND_OPENAT, '0);
    // largest latency saturates to the last bin
    send(MODE_ENTER, k3, '1, 1'b1, KIND_READ, '0);
    send(MODE_EXIT, k3, 64'hffff_ffff_ffff_fffe, 1'b0, KIND_READ, '0);
    // unknown call kind frees the entry
    send(MODE_ENTER, k3, '0, 1'b1, KIND_READ, '0);
    send(MODE_EXIT, k3, 64'd7, 1'b0, KIND_NONE, '0);
    send(MODE_EXIT, k3, 64'd9, 1'b0, KIND_READ, '0);
    send(MODE_ENTER, k0, '0, 1'b1, KIND_READ, '0);
    send(MODE_EXIT, k0, 64'h8000_0000, 1'b0, KIND_OPENAT, '0);
    send(MODE_READ_BIN, '0, '0, 1'b0, KIND_OPENAT, SEL_W'(HIST_BINS - 1));
    send(MODE_READ_BIN, '0, '0, 1'b0, KIND_READ, '0);
    send(MODE_READ_DROP, '1, '1, 1'b1, KIND_NONE, '1);
  endtask

  task automatic random_request();
    int               pick;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (pick < 40) begin
      send(MODE_ENTER, key, rand64(), 1'b1, KIND_W'($urandom), SEL_W'($urandom));
    end else if (pick < 45) begin
      send(MODE_ENTER, $urandom_range(0, 1) ? key : rand64(), rand64(), 1'b0,
           KIND_W'($urandom), SEL_W'($urandom));
    end else if (pick < 80) begin
      send_exit(key, random_kind());
    end else if (pick < 85) begin
      send_exit(rand64(), random_kind());
    end else if (pick < 97) begin
      send(MODE_READ_BIN, rand64(), rand64(), 1'($urandom), KIND_W'($urandom_range(0, 3)),
           SEL_W'($urandom));
    end else begin
      send(MODE_READ_DROP, rand64(), rand64(), 1'($urandom), KIND_W'($urandom),
           SEL_W'($urandom));
    end
  endtask

  task automatic random_phase(int count, bit quiet_tail);
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_odds = 0;
          1:       idle_odds = 25;
          default: idle_odds = 60;
        endcase
      end
      if (quiet_tail && n >= count - TAIL_ITEMS) allow_idle = 1'b0;
      random_request();
    end
  endtask

  task automatic fill_and_drain();
    logic [CNT_W-1:0] drop_mark;
    logic [KEY_W-1:0] low_key;
    logic [KEY_W-1:0] high_key;
    logic [KEY_W-1:0] fresh_a;
    logic [KEY_W-1:0] fresh_b;
    wait_drained();
    drop_mark = latency_sb.drops;
    while (latency_sb.drops < drop_mark + 4) begin
      send(MODE_ENTER, rand64(), rand64(), 1'b1, KIND_W'($urandom), SEL_W'($urandom));
    end
    send(MODE_READ_DROP, rand64(), rand64(), 1'($urandom), KIND_W'($urandom), SEL_W'($urandom));
    // full table: overwrite still stores, filtered enter does nothing
    send(MODE_ENTER, latency_sb.slot_key[$urandom_range(0, TABLE_ENTRIES - 1)], rand64(), 1'b1,
         KIND_W'($urandom), SEL_W'($urandom));
    send(MODE_ENTER, rand64(), rand64(), 1'b0, KIND_W'($urandom), SEL_W'($urandom));
    // free two slots and refill them, then overflow again
    low_key  = latency_sb.slot_key[3];
    high_key = latency_sb.slot_key[TABLE_ENTRIES - 100];
    send_exit(high_key, KIND_WRITE);
    send_exit(low_key, KIND_READ);
    fresh_a = rand64();
    fresh_b = rand64();
    send(MODE_ENTER, fresh_a, rand64(), 1'b1, KIND_W'($urandom), SEL_W'($urandom));
    send(MODE_ENTER, fresh_b, rand64(), 1'b1, KIND_W'($urandom), SEL_W'($urandom));
    send(MODE_ENTER, rand64(), rand64(), 1'b1, KIND_W'($urandom), SEL_W'($urandom));
    send_exit(fresh_a, KIND_OPENAT);
    send_exit(fresh_b, KIND_WRITE);
    send(MODE_READ_DROP, rand64(), rand64(), 1'($urandom), KIND_W'($urandom), SEL_W'($urandom));
    for (int k = 0; k < CALL_KINDS; k++) begin
      send(MODE_READ_BIN, rand64(), rand64(), 1'($urandom), KIND_W'(k), SEL_W'($urandom));
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = rand64();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    directed_requests();
    wait_drained();
    random_phase(30, 1'b0);
    fill_and_drain();
    allow_idle = 1'b1;
    random_phase(60, 1'b1);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (latency_sb.fails == 0 && latency_sb.pending.size() == 0) begin
      $display("interval_latency_log2_histogram_unit regression: pass");
    end else begin
      $display("interval_latency_log2_histogram_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== interval_latency_log2_histogram_unit.f =====
+incdir+sv
sv/ilh_pkg.sv
sv/ilh_ram.sv
sv/ilh_log2.sv
sv/ilh_cell.sv
sv/interval_latency_log2_histogram_unit.sv
dv/tb_interval_latency_log2_histogram_unit.sv
